>>> rtl/sba_pkg.sv
// shared types, constants and tables of the size-class buffer allocator
package sba_pkg;

  localparam int NUM_CLASSES = 6;
  localparam int STACK_DEPTH = 256;
  localparam int MAP_ENTRIES = 32;

  localparam int GRANULE_SHIFT = 6;
  localparam int ADDR_W        = 32;
  localparam int SIZE_W        = 12;
  localparam int CLS_W         = 3;
  localparam int CLS_IDX_W     = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int MAP_IDX_W     = $clog2(MAP_ENTRIES);
  localparam int CNT_W         = $clog2(STACK_DEPTH + 1);
  localparam int SLOT_W        = $clog2(STACK_DEPTH);
  localparam int MEM_DEPTH     = NUM_CLASSES * STACK_DEPTH;
  localparam int MEM_AW        = $clog2(MEM_DEPTH);
  localparam int TOTAL_W       = 17;
  localparam int GIDX_W        = TOTAL_W - GRANULE_SHIFT;

  // register indexes of the configuration port
  localparam logic [2:0] CFG_POOL_BASE   = 3'd0;
  localparam logic [2:0] CFG_POOL_SIZE   = 3'd1;
  localparam logic [2:0] CFG_ALIGN_SIZE  = 3'd2;
  localparam logic [2:0] CFG_HEADER      = 3'd3;
  localparam logic [2:0] CFG_FREE_MASK   = 3'd4;

  localparam logic [SIZE_W-1:0] CLASS_BYTES [NUM_CLASSES] = '{
    12'd64, 12'd128, 12'd256, 12'd512, 12'd1024, 12'd2048
  };

  localparam logic [CLS_W-1:0] CLASS_MAP [MAP_ENTRIES] = '{
    3'd0, 3'd1, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3, 3'd3,
    3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4,
    3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5,
    3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5
  };

  typedef enum logic [1:0] {
    REQ_ALLOC     = 2'd0,
    REQ_FREE      = 2'd1,
    REQ_COND_FREE = 2'd2,
    REQ_RSVD      = 2'd3
  } sba_req_t;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_TOO_LARGE = 3'd1,
    STAT_EXHAUSTED = 3'd2,
    STAT_SKIPPED   = 3'd3,
    STAT_OVERFLOW  = 3'd4
  } sba_status_t;

  typedef enum logic [1:0] {
    OP_ALLOC,
    OP_PUSH,
    OP_REJECT
  } sba_op_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MEM,
    ST_RESP
  } sba_state_t;

  // decoded request, held while the stack engine works on it
  typedef struct packed {
    sba_op_kind_t       kind;
    sba_status_t        rej_status;
    logic [CLS_W-1:0]   cls;
    logic [ADDR_W-1:0]  addr;
  } sba_op_t;

  // outcome of the stack access, registered by the engine
  typedef struct packed {
    sba_status_t        status;
    logic               is_alloc;
    logic               pop;
    logic [ADDR_W-1:0]  bump_addr;
    logic [SIZE_W-1:0]  usable;
    logic [CLS_W-1:0]   cls;
  } sba_res_t;

  function automatic logic [MEM_AW-1:0] stack_entry(logic [CLS_W-1:0] cls,
                                                    logic [SLOT_W-1:0] slot);
    stack_entry = MEM_AW'(cls) * MEM_AW'(STACK_DEPTH) + MEM_AW'(slot);
  endfunction

endpackage

>>> rtl/sba_req_decode.sv
// request decode: size to class mapping and free qualification
module sba_req_decode (
  input  logic [1:0]                req_type,
  input  logic [15:0]               buf_size,
  input  logic [15:0]               pkg_flag,
  input  logic [31:0]               block_addr,
  input  logic [2:0]                free_class,
  input  logic [8:0]                align_size,
  input  logic [7:0]                header_bytes,
  input  logic [15:0]               free_flag_mask,
  output sba_pkg::sba_op_t          op
);

  logic [sba_pkg::TOTAL_W-1:0] total;
  logic [sba_pkg::GIDX_W-1:0]  gidx;
  logic [sba_pkg::CLS_W-1:0]   map_cls;
  logic                        too_large;
  logic                        flag_ok;

  assign total     = sba_pkg::TOTAL_W'(buf_size) + sba_pkg::TOTAL_W'(header_bytes)
                   + sba_pkg::TOTAL_W'(align_size);
  assign gidx      = total[sba_pkg::TOTAL_W-1:sba_pkg::GRANULE_SHIFT];
  assign map_cls   = sba_pkg::CLASS_MAP[gidx[sba_pkg::MAP_IDX_W-1:0]];
  assign too_large = (gidx >= sba_pkg::GIDX_W'(sba_pkg::MAP_ENTRIES))
                   || (map_cls >= sba_pkg::CLS_W'(sba_pkg::NUM_CLASSES));
  assign flag_ok   = (pkg_flag & free_flag_mask) != 16'd0;

  always_comb begin
    op.kind       = sba_pkg::OP_REJECT;
    op.rej_status = sba_pkg::STAT_SKIPPED;
    op.cls        = free_class;
    op.addr       = block_addr;
    unique case (sba_pkg::sba_req_t'(req_type))
      sba_pkg::REQ_ALLOC: begin
        op.cls = map_cls;
        if (too_large) begin
          op.rej_status = sba_pkg::STAT_TOO_LARGE;
        end else begin
          op.kind = sba_pkg::OP_ALLOC;
        end
      end
      sba_pkg::REQ_FREE: begin
        if (free_class < sba_pkg::CLS_W'(sba_pkg::NUM_CLASSES)) begin
          op.kind = sba_pkg::OP_PUSH;
        end
      end
      sba_pkg::REQ_COND_FREE: begin
        if (free_class < sba_pkg::CLS_W'(sba_pkg::NUM_CLASSES) && flag_ok) begin
          op.kind = sba_pkg::OP_PUSH;
        end
      end
      default: begin
        op.kind = sba_pkg::OP_REJECT;
      end
    endcase
  end

endmodule

>>> rtl/sba_stack_engine.sv
// free-stack memory with per-class counts and the bump pointer
module sba_stack_engine (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          go,
  input  sba_pkg::sba_op_t              op,
  input  logic [31:0]                   pool_base,
  input  logic [31:0]                   pool_size,
  input  logic [7:0]                    header_bytes,
  output sba_pkg::sba_res_t             res,
  output logic [sba_pkg::ADDR_W-1:0]    rdata
);

  logic [sba_pkg::ADDR_W-1:0] mem [sba_pkg::MEM_DEPTH];
  logic [sba_pkg::CNT_W-1:0]  count [sba_pkg::NUM_CLASSES];
  logic [31:0]                bump;
  logic [31:0]                bump_next;

  logic [sba_pkg::CLS_IDX_W-1:0] cidx;
  logic [sba_pkg::CNT_W-1:0]     cnt;
  logic [sba_pkg::CNT_W-1:0]     cnt_next;
  logic [sba_pkg::SIZE_W-1:0]    csize;
  logic [32:0]                   bump_end;
  logic                          fits;
  logic                          mem_we;
  logic                          mem_re;
  logic [sba_pkg::MEM_AW-1:0]    mem_addr;
  sba_pkg::sba_res_t             res_next;

  assign cidx     = op.cls[sba_pkg::CLS_IDX_W-1:0];
  assign cnt      = count[cidx];
  assign csize    = sba_pkg::CLASS_BYTES[cidx];
  assign bump_end = 33'(csize) + 33'(bump);
  assign fits     = bump_end < 33'(pool_size);

  always_comb begin
    res_next.status    = op.rej_status;
    res_next.is_alloc  = 1'b0;
    res_next.pop       = 1'b0;
    res_next.bump_addr = pool_base + bump;
    res_next.usable    = (csize > sba_pkg::SIZE_W'(header_bytes))
                       ? csize - sba_pkg::SIZE_W'(header_bytes) : '0;
    res_next.cls       = op.cls;
    cnt_next           = cnt;
    bump_next          = bump;
    mem_we             = 1'b0;
    mem_re             = 1'b0;
    mem_addr           = sba_pkg::stack_entry(op.cls, cnt[sba_pkg::SLOT_W-1:0]);
    unique case (op.kind)
      sba_pkg::OP_ALLOC: begin
        if (cnt != '0) begin
          // pop the top of the class stack
          res_next.status   = sba_pkg::STAT_OK;
          res_next.is_alloc = 1'b1;
          res_next.pop      = 1'b1;
          cnt_next          = cnt - 1'b1;
          mem_re            = 1'b1;
          mem_addr          = sba_pkg::stack_entry(op.cls, cnt_next[sba_pkg::SLOT_W-1:0]);
        end else if (fits) begin
          res_next.status   = sba_pkg::STAT_OK;
          res_next.is_alloc = 1'b1;
          bump_next         = bump + 32'(csize);
        end else begin
          res_next.status   = sba_pkg::STAT_EXHAUSTED;
        end
      end
      sba_pkg::OP_PUSH: begin
        if (cnt >= sba_pkg::CNT_W'(sba_pkg::STACK_DEPTH)) begin
          res_next.status = sba_pkg::STAT_OVERFLOW;
        end else begin
          res_next.status = sba_pkg::STAT_OK;
          cnt_next        = cnt + 1'b1;
          mem_we          = 1'b1;
        end
      end
      default: begin
        res_next.status = op.rej_status;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bump <= '0;
      for (int i = 0; i < sba_pkg::NUM_CLASSES; i++) begin
        count[i] <= '0;
      end
    end else if (go) begin
      bump        <= bump_next;
      count[cidx] <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      res <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (go && mem_we) begin
      mem[mem_addr] <= op.addr;
    end
    if (go && mem_re) begin
      rdata <= mem[mem_addr];
    end
  end

endmodule

>>> rtl/size_class_buffer_allocator_unit.sv
// top level of the size-class packet-buffer allocator
//
//   channel   handshake                 word
//   request   start / busy              req_type buf_size pkg_flag block_addr free_class
//   result    done (one-cycle strobe)   status alloc_addr usable_size align_offset size_class
//   config    cfg_valid / cfg_ready     cfg_index cfg_data
//
// a request runs as follows: the accept edge registers the decoded request,
// the memory state reads or writes the class stack memory and updates the count,
// and the response state then shows the result with done
// a new request is taken in the same cycle that done is high; none is taken
// while busy is high in the memory state
// reset (rst, synchronous) restores the register defaults, empties all class
// stacks and zeroes the bump pointer; the stack memory itself is not cleared
// the receiver cannot stall, so nothing waits on the result side
module size_class_buffer_allocator_unit (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type,
  input  logic [15:0] buf_size,
  input  logic [15:0] pkg_flag,
  input  logic [31:0] block_addr,
  input  logic [2:0]  free_class,
  // result channel
  output logic        done,
  output logic [2:0]  status,
  output logic [31:0] alloc_addr,
  output logic [11:0] usable_size,
  output logic [7:0]  align_offset,
  output logic [2:0]  size_class,
  // configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  // configuration registers
  logic [31:0] pool_base;
  logic [31:0] pool_size;
  logic [8:0]  align_size;
  logic [7:0]  header_bytes;
  logic [15:0] free_flag_mask;

  sba_pkg::sba_state_t state;
  sba_pkg::sba_state_t state_next;
  sba_pkg::sba_op_t    op_dec;
  sba_pkg::sba_op_t    op;
  sba_pkg::sba_res_t   res;
  logic [31:0]         rdata;
  logic                accept;
  logic                go;

  // result formatting
  logic        ok_alloc;
  logic [31:0] out_addr;
  logic [31:0] buf_start;
  logic [8:0]  align_mask;
  logic [8:0]  low_bits;
  logic [8:0]  pad;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base      <= 32'd0;
      pool_size      <= 32'd65536;
      align_size     <= 9'd16;
      header_bytes   <= 8'd32;
      free_flag_mask <= 16'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sba_pkg::CFG_POOL_BASE:  pool_base      <= cfg_data;
        sba_pkg::CFG_POOL_SIZE:  pool_size      <= cfg_data;
        sba_pkg::CFG_ALIGN_SIZE: align_size     <= cfg_data[8:0];
        sba_pkg::CFG_HEADER:     header_bytes   <= cfg_data[7:0];
        sba_pkg::CFG_FREE_MASK:  free_flag_mask <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // size mapping and free checks on the port values
  sba_req_decode u_decode (
    .req_type       (req_type),
    .buf_size       (buf_size),
    .pkg_flag       (pkg_flag),
    .block_addr     (block_addr),
    .free_class     (free_class),
    .align_size     (align_size),
    .header_bytes   (header_bytes),
    .free_flag_mask (free_flag_mask),
    .op             (op_dec)
  );

  // decoded request held for the memory cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      op <= op_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sba_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    unique case (state)
      sba_pkg::ST_IDLE: state_next = start ? sba_pkg::ST_MEM : sba_pkg::ST_IDLE;
      sba_pkg::ST_MEM:  state_next = sba_pkg::ST_RESP;
      sba_pkg::ST_RESP: state_next = start ? sba_pkg::ST_MEM : sba_pkg::ST_IDLE;
      default:          state_next = sba_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy = 1'b0;
    done = 1'b0;
    go   = 1'b0;
    unique case (state)
      sba_pkg::ST_IDLE: ;
      sba_pkg::ST_MEM: begin
        busy = 1'b1;
        go   = 1'b1;
      end
      sba_pkg::ST_RESP: done = 1'b1;
      default: ;
    endcase
  end

  // pop, push, bump and count update in the memory state
  sba_stack_engine u_engine (
    .clk          (clk),
    .rst          (rst),
    .go           (go),
    .op           (op),
    .pool_base    (pool_base),
    .pool_size    (pool_size),
    .header_bytes (header_bytes),
    .res          (res),
    .rdata        (rdata)
  );

  // popped address comes straight from the memory read register
  assign ok_alloc   = res.is_alloc && (res.status == sba_pkg::STAT_OK);
  assign out_addr   = res.pop ? rdata : res.bump_addr;
  assign buf_start  = out_addr + 32'(header_bytes);
  assign align_mask = align_size - 9'd1;
  assign low_bits   = buf_start[8:0] & align_mask;
  assign pad        = align_size - low_bits;

  assign status       = res.status;
  assign alloc_addr   = ok_alloc ? out_addr : 32'd0;
  assign usable_size  = ok_alloc ? res.usable : 12'd0;
  assign size_class   = ok_alloc ? res.cls : 3'd0;
  // no padding when alignment is zero or the buffer already sits aligned
  assign align_offset = (ok_alloc && align_size != 9'd0 && low_bits != 9'd0)
                      ? pad[7:0] : 8'd0;

endmodule

>>> rtl/sba_checker.sv
// port-level checks of the allocator, bound to the top level
module sba_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [2:0]  status,
  input logic [31:0] alloc_addr,
  input logic [11:0] usable_size,
  input logic [7:0]  align_offset,
  input logic [2:0]  size_class
);

  // an accepted request occupies the block for its memory cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted request did not enter its memory cycle");

  // every memory cycle ends in exactly one result
  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    busy |=> done && !busy)
    else $error("memory cycle not followed by a result");

  // a result never appears without a memory cycle before it
  a_done_past: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a preceding memory cycle");

  // failed results (status not OK) carry zero payload
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    done && status != sba_pkg::STAT_OK |-> alloc_addr == 32'd0 && usable_size == 12'd0
      && align_offset == 8'd0 && size_class == 3'd0)
    else $error("failed request carries a nonzero payload");

endmodule

bind size_class_buffer_allocator_unit sba_checker u_sba_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .done         (done),
  .status       (status),
  .alloc_addr   (alloc_addr),
  .usable_size  (usable_size),
  .align_offset (align_offset),
  .size_class   (size_class)
);
